>>> hdl/xks_pkg.sv
// shared types, codes and constants for the xorshift keystream image cipher
`timescale 1ns / 1ps

package xks_pkg;

  localparam int DEF_WINDOW_WORDS = 16;
  localparam int DEF_INDEX_BITS = 30;

  localparam int WORD_BITS = 32;
  localparam int KEY_BITS = 64;
  localparam int WS_BITS = 30;
  localparam int CFG_INDEX_BITS = 3;

  localparam int SHIFT_A = 11;
  localparam int SHIFT_B = 19;
  localparam int SHIFT_C = 8;

  localparam logic [WS_BITS-1:0] WS_RESET = WS_BITS'(128);

  typedef enum logic [1:0] {
    OP_RESTART = 2'd0,
    OP_DATA    = 2'd1,
    OP_SKIP    = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    MODE_A    = 2'd0,
    MODE_B    = 2'd1,
    MODE_BOTH = 2'd2
  } mode_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MODE         = 3'd0,
    REG_KEY_A_LOW    = 3'd1,
    REG_KEY_A_HIGH   = 3'd2,
    REG_KEY_B_LOW    = 3'd3,
    REG_KEY_B_HIGH   = 3'd4,
    REG_WINDOW_START = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]           opcode;
    logic [WORD_BITS-1:0] data_word;
    logic                 last;
  } in_item_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] out_word;
    logic [WORD_BITS-1:0] sum_raw;
    logic [WORD_BITS-1:0] sum_dec;
    logic                 last_out;
    logic                 image_ok;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic step;
  } gen_ctrl_t;

endpackage

>>> hdl/xks_gen.sv
// xorshift128 generator with seed load and single step per cycle
`timescale 1ns / 1ps

module xks_gen (
  input  logic                          clk,
  input  logic                          rst,
  input  xks_pkg::gen_ctrl_t            ctrl,
  input  logic [xks_pkg::KEY_BITS-1:0]  seed_low,
  input  logic [xks_pkg::KEY_BITS-1:0]  seed_high,
  output logic [xks_pkg::WORD_BITS-1:0] ks
);
  import xks_pkg::*;

  logic [WORD_BITS-1:0] x;
  logic [WORD_BITS-1:0] y;
  logic [WORD_BITS-1:0] z;
  logic [WORD_BITS-1:0] w;
  logic [WORD_BITS-1:0] t;

  always_comb begin
    t  = x ^ (x << SHIFT_A);
    ks = w ^ (w >> SHIFT_B) ^ t ^ (t >> SHIFT_C);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x <= '0;
      y <= '0;
      z <= '0;
      w <= '0;
    end else if (ctrl.load) begin
      x <= seed_low[KEY_BITS-1:WORD_BITS];
      y <= seed_high[WORD_BITS-1:0];
      z <= seed_high[KEY_BITS-1:WORD_BITS];
      w <= seed_low[WORD_BITS-1:0];
    end else if (ctrl.step) begin
      x <= y;
      y <= z;
      z <= w;
      w <= ks;
    end
  end

endmodule

>>> hdl/xorshift_keystream_image_cipher_core.sv
// top level: request register, keystream generators, sums and result register
// a data request is held in the request register and its result is registered in the result register
// throughput: one request per cycle while the result side does not stall, set by one generator step and one 32-bit add
// requests that give no result (restart, skip, none) still occupy the request stage
// synchronous reset clears generators, index, sums, valids and loads register defaults
// stall from the result side reaches the request stall in the same cycle
`timescale 1ns / 1ps

module xorshift_keystream_image_cipher_core #(
  parameter int WINDOW_WORDS = xks_pkg::DEF_WINDOW_WORDS,
  parameter int INDEX_BITS   = xks_pkg::DEF_INDEX_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  xks_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output xks_pkg::out_item_t                 out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [xks_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [xks_pkg::KEY_BITS-1:0]       cfg_data
);
  import xks_pkg::*;

  localparam int CMP_W = ((INDEX_BITS > WS_BITS) ? INDEX_BITS : WS_BITS) + 1;

  // configuration registers
  logic [1:0]          mode;
  logic [KEY_BITS-1:0] key_a_low;
  logic [KEY_BITS-1:0] key_a_high;
  logic [KEY_BITS-1:0] key_b_low;
  logic [KEY_BITS-1:0] key_b_high;
  logic [WS_BITS-1:0]  window_start;

  // request stage
  logic     s1_valid;
  in_item_t s1_item;

  // running state
  logic [INDEX_BITS-1:0] word_index;
  logic [WORD_BITS-1:0]  raw_total;
  logic [WORD_BITS-1:0]  plain_total;

  logic                 advance;
  logic                 process;
  logic                 is_restart;
  logic                 is_step;
  logic                 is_data;
  gen_ctrl_t            gen_ctrl;
  logic [WORD_BITS-1:0] ks_a;
  logic [WORD_BITS-1:0] ks_b;
  logic [CMP_W-1:0]     idx_ext;
  logic [CMP_W-1:0]     ws_ext;
  logic [CMP_W-1:0]     diff;
  logic                 in_window;
  logic [WORD_BITS-1:0] result;
  logic [WORD_BITS-1:0] raw_total_next;
  logic [WORD_BITS-1:0] plain_total_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_B;
      key_a_low    <= '0;
      key_a_high   <= '0;
      key_b_low    <= '0;
      key_b_high   <= '0;
      window_start <= WS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE:         mode         <= cfg_data[1:0];
        REG_KEY_A_LOW:    key_a_low    <= cfg_data;
        REG_KEY_A_HIGH:   key_a_high   <= cfg_data;
        REG_KEY_B_LOW:    key_b_low    <= cfg_data;
        REG_KEY_B_HIGH:   key_b_high   <= cfg_data;
        REG_WINDOW_START: window_start <= cfg_data[WS_BITS-1:0];
        default:          ;
      endcase
    end
  end

  // flow control
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign process  = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= in_data;
    end
  end

  always_comb begin
    is_restart = process && (s1_item.opcode == OP_RESTART);
    is_data    = process && (s1_item.opcode == OP_DATA);
    is_step    = is_data || (process && (s1_item.opcode == OP_SKIP));
    gen_ctrl   = '{load: is_restart, step: is_step};
  end

  xks_gen u_gen_a (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (gen_ctrl),
    .seed_low  (key_a_low),
    .seed_high (key_a_high),
    .ks        (ks_a)
  );

  xks_gen u_gen_b (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (gen_ctrl),
    .seed_low  (key_b_low),
    .seed_high (key_b_high),
    .ks        (ks_b)
  );

  // verbatim window and word transform
  always_comb begin
    idx_ext   = CMP_W'(word_index);
    ws_ext    = CMP_W'(window_start);
    diff      = idx_ext - ws_ext;
    in_window = (idx_ext >= ws_ext) && (diff < CMP_W'(WINDOW_WORDS));
    if (in_window) begin
      result = s1_item.data_word;
    end else begin
      case (s1_item.opcode == OP_DATA ? mode : MODE_A)
        MODE_A:  result = s1_item.data_word ^ ks_a;
        MODE_B:  result = s1_item.data_word ^ ks_b;
        default: result = s1_item.data_word ^ ks_a ^ ks_b;
      endcase
    end
    raw_total_next   = raw_total + s1_item.data_word;
    plain_total_next = plain_total + result;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_index  <= '0;
      raw_total   <= '0;
      plain_total <= '0;
    end else if (is_restart) begin
      word_index  <= '0;
      raw_total   <= '0;
      plain_total <= '0;
    end else begin
      if (is_step) begin
        word_index <= word_index + INDEX_BITS'(1);
      end
      if (is_data) begin
        raw_total   <= raw_total_next;
        plain_total <= plain_total_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (is_data) begin
      out_valid <= 1'b1;
    end else if (advance) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_data) begin
      out_data.out_word <= result;
      out_data.sum_raw  <= raw_total_next;
      out_data.sum_dec  <= plain_total_next;
      out_data.last_out <= s1_item.last;
      out_data.image_ok <= s1_item.last && (plain_total_next == '0);
    end
  end

  // checks
  a_result_from_data: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid && (s1_item.opcode == OP_DATA)))
    else $error("result appeared without a data request");

  a_ok_means_zero_sum: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.image_ok) |-> (out_data.last_out && (out_data.sum_dec == '0)))
    else $error("image accepted with non-zero sum or not last");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    is_restart |=> ((word_index == '0) && (raw_total == '0) && (plain_total == '0)))
    else $error("restart did not clear index and sums");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !in_stall)
    else $error("request stalled while the stage is empty");

endmodule
